### hdl/owtsd_pkg.sv
package owtsd_pkg;

    localparam int FRAME_BYTES = 9;
    localparam int CNT_W = 4;
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_BYTES - 1);
    localparam logic [CNT_W-1:0] IDX_TEMP_LSB = CNT_W'(0);
    localparam logic [CNT_W-1:0] IDX_TEMP_MSB = CNT_W'(1);
    localparam logic [CNT_W-1:0] IDX_REMAIN = CNT_W'(6);

    localparam logic [7:0] EXT_FAMILY = 8'h10;
    localparam logic [7:0] CRC_POLY = 8'h8C;

    // 1-Wire CRC-8, reflected, lsb first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### hdl/owtsd_temp.sv
module owtsd_temp
(
    input  logic [7:0]         temp_low,
    input  logic [7:0]         temp_high,
    input  logic [7:0]         remain_count,
    input  logic [7:0]         family_code,
    output logic signed [15:0] temperature
);

    logic signed [15:0] word;
    logic signed [15:0] half;
    logic signed [19:0] ext_sum;

    // ext: (word >>> 1) * 16 + 12 - remain, saturated
    always_comb
    begin
        word = signed'({temp_high, temp_low});
        half = word >>> 1;
        ext_sum = signed'({half, 4'b0000}) + 20'sd12 - signed'({12'd0, remain_count});
        if (family_code != owtsd_pkg::EXT_FAMILY)
        begin
            temperature = word;
        end
        else if (ext_sum > 20'sd32767)
        begin
            temperature = 16'sh7FFF;
        end
        else if (ext_sum < -20'sd32768)
        begin
            temperature = 16'sh8000;
        end
        else
        begin
            temperature = ext_sum[15:0];
        end
    end

endmodule

### hdl/onewire_temp_scratchpad_decode.sv
// channel | signals                                    | role
// in      | in_valid, in_stall, data_byte,             | one scratchpad byte per item
//         | family_code, frame_start                   |
// out     | out_valid, out_stall, temperature,         | one item per completed frame
//         | crc_error                                  |
//
// One byte per cycle unless the input stalls; the CRC byte's result appears in the
// cycle after it is taken, set by the single result register.
// Reset clears the byte count, CRC and captured bytes, and empties the result register.
// Input stalls only while a result is held and the output is stalled.
module onewire_temp_scratchpad_decode
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic [7:0]         family_code,
    input  logic               frame_start,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] temperature,
    output logic               crc_error
);

    logic [owtsd_pkg::CNT_W-1:0] byte_count_reg;
    logic [owtsd_pkg::CNT_W-1:0] idx;
    logic [7:0]                  crc_accum_reg;
    logic [7:0]                  crc_next;
    logic [7:0]                  temp_low_reg;
    logic [7:0]                  temp_high_reg;
    logic [7:0]                  remain_count_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic signed [15:0]          temperature_reg;
    logic                        crc_error_reg;
    logic signed [15:0]          temp_calc;
    logic                        in_accept;
    logic                        is_last;
    logic                        bad;

    assign in_stall = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;
    assign idx = frame_start ? owtsd_pkg::IDX_TEMP_LSB : byte_count_reg;
    assign is_last = idx >= owtsd_pkg::LAST_IDX;
    assign bad = crc_accum_reg != data_byte;
    assign crc_next = owtsd_pkg::crc8_byte(
        (idx == owtsd_pkg::IDX_TEMP_LSB) ? 8'h00 : crc_accum_reg, data_byte);
    assign out_valid_next = (in_accept & is_last) | (out_valid_reg & out_stall);

    owtsd_temp u_temp
    (
        .temp_low     (temp_low_reg),
        .temp_high    (temp_high_reg),
        .remain_count (remain_count_reg),
        .family_code  (family_code),
        .temperature  (temp_calc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            crc_accum_reg    <= '0;
            temp_low_reg     <= '0;
            temp_high_reg    <= '0;
            remain_count_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                if (is_last)
                begin
                    byte_count_reg <= '0;
                end
                else
                begin
                    byte_count_reg <= idx + 1'b1;
                    crc_accum_reg  <= crc_next;
                    if (idx == owtsd_pkg::IDX_TEMP_LSB)
                    begin
                        temp_low_reg <= data_byte;
                    end
                    else if (idx == owtsd_pkg::IDX_TEMP_MSB)
                    begin
                        temp_high_reg <= data_byte;
                    end
                    else if (idx == owtsd_pkg::IDX_REMAIN)
                    begin
                        remain_count_reg <= data_byte;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && is_last)
        begin
            temperature_reg <= bad ? 16'sd0 : temp_calc;
            crc_error_reg   <= bad;
        end
    end

    assign out_valid   = out_valid_reg;
    assign temperature = temperature_reg;
    assign crc_error   = crc_error_reg;

endmodule

### tb/sv/tb.sv
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed
    {
        logic [7:0] data;
        logic [7:0] family;
        logic       start;
    } scratch_byte_t;

    typedef struct packed
    {
        logic signed [15:0] temp;
        logic               crc_err;
    } reading_t;

    localparam int N_ITEMS = 1650;
    localparam int HOLD_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         data_byte = '0;
    logic [7:0]         family_code = '0;
    logic               frame_start = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] temperature;
    logic               crc_error;

    scratch_byte_t pending_bytes[$];
    reading_t      expected_readings[$];

    // decoder shadow state
    logic [3:0] frame_idx = '0;
    logic [7:0] crc_run = '0;
    logic [7:0] t_lsb = '0;
    logic [7:0] t_msb = '0;
    logic [7:0] remain = '0;

    int n_total = 0;
    int n_taken = 0;
    int n_frames = 0;
    int n_ext = 0;
    int n_sat = 0;
    int n_bad_crc = 0;
    int n_readings = 0;
    int n_errors = 0;
    int idle_phase = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    always #2 clk = ~clk;

    onewire_temp_scratchpad_decode i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .family_code (family_code),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .temperature (temperature),
        .crc_error   (crc_error)
    );

    // 1-Wire CRC-8, one data bit at a time, lsb first
    function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        r = acc;
        for (int i = 0; i < 8; i++)
        begin
            fb = r[0] ^ b[i];
            r = r >> 1;
            if (fb)
            begin
                r = r ^ owtsd_pkg::CRC_POLY;
            end
        end
        return r;
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic [7:0] fam, input logic st);
        logic [3:0]         idx;
        logic signed [15:0] word;
        int                 t;
        int                 rem;
        reading_t           rd;
        idx = st ? owtsd_pkg::IDX_TEMP_LSB : frame_idx;
        if (idx >= owtsd_pkg::LAST_IDX)
        begin
            n_frames++;
            if (crc_run != b)
            begin
                rd.temp = '0;
                rd.crc_err = 1'b1;
                n_bad_crc++;
            end
            else if (fam != owtsd_pkg::EXT_FAMILY)
            begin
                rd.temp = {t_msb, t_lsb};
                rd.crc_err = 1'b0;
            end
            else
            begin
                n_ext++;
                word = {t_msb, t_lsb};
                t = word >>> 1;
                rem = remain;
                t = t * 16 - 4 + (16 - rem);
                if (t > 32767)
                begin
                    t = 32767;
                    n_sat++;
                end
                else if (t < -32768)
                begin
                    t = -32768;
                    n_sat++;
                end
                rd.temp = t[15:0];
                rd.crc_err = 1'b0;
            end
            expected_readings.push_back(rd);
            frame_idx = '0;
        end
        else
        begin
            if (idx == owtsd_pkg::IDX_TEMP_LSB)
            begin
                crc_run = '0;
                t_lsb = b;
            end
            else if (idx == owtsd_pkg::IDX_TEMP_MSB)
            begin
                t_msb = b;
            end
            else if (idx == owtsd_pkg::IDX_REMAIN)
            begin
                remain = b;
            end
            crc_run = crc_step(crc_run, b);
            frame_idx = idx + 4'd1;
        end
    endtask

    task automatic add_frame(input logic [15:0] tw, input logic [7:0] rem,
                             input logic [7:0] fam, input bit with_start, input bit corrupt);
        logic [7:0]    b[owtsd_pkg::FRAME_BYTES];
        logic [7:0]    crc;
        scratch_byte_t it;
        crc = '0;
        for (int i = 0; i < owtsd_pkg::FRAME_BYTES - 1; i++)
        begin
            b[i] = 8'($urandom);
        end
        b[owtsd_pkg::IDX_TEMP_LSB] = tw[7:0];
        b[owtsd_pkg::IDX_TEMP_MSB] = tw[15:8];
        b[owtsd_pkg::IDX_REMAIN] = rem;
        for (int i = 0; i < owtsd_pkg::FRAME_BYTES - 1; i++)
        begin
            crc = crc_step(crc, b[i]);
        end
        b[owtsd_pkg::LAST_IDX] = corrupt ? crc ^ 8'($urandom_range(1, 255)) : crc;
        for (int i = 0; i < owtsd_pkg::FRAME_BYTES; i++)
        begin
            it.data = b[i];
            it.family = (i == owtsd_pkg::LAST_IDX) ? fam : 8'($urandom);
            it.start = (i == 0) ? with_start : 1'b0;
            pending_bytes.push_back(it);
        end
    endtask

    // partial or junk bytes; the next frame must carry a start
    task automatic add_noise(input int n);
        scratch_byte_t it;
        for (int i = 0; i < n; i++)
        begin
            it.data = 8'($urandom);
            it.family = 8'($urandom);
            it.start = (i == 0) ? 1'b1 : ($urandom_range(0, 7) == 0);
            pending_bytes.push_back(it);
        end
    endtask

    function automatic logic [15:0] pick_temp();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'hFFFF;
            3: return 16'h0000;
            4: return 16'($signed($urandom_range(0, 400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        int idle_pct;
        scratch_byte_t it;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            data_byte <= '0;
            family_code <= '0;
            frame_start <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                decode_byte(data_byte, family_code, frame_start);
                n_taken++;
            end
            idle_phase <= (n_taken < n_total / 3) ? 0 : (n_taken < 2 * n_total / 3) ? 1 : 2;
            idle_pct = (idle_phase == 0) ? 32 : (idle_phase == 1) ? 80 : 0;
            if (!(in_valid && in_stall))
            begin
                if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    it = pending_bytes.pop_front();
                    in_valid <= 1'b1;
                    data_byte <= it.data;
                    family_code <= it.family;
                    frame_start <= it.start;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        int stall_pct;
        reading_t rd;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                n_readings++;
                if (expected_readings.size() == 0)
                begin
                    $error("unexpected item: temperature %0d crc_error %0b",
                           temperature, crc_error);
                    n_errors++;
                end
                else
                begin
                    rd = expected_readings.pop_front();
                    if (temperature !== rd.temp)
                    begin
                        $error("temperature: expected %0d, got %0d", rd.temp, temperature);
                        n_errors++;
                    end
                    if (crc_error !== rd.crc_err)
                    begin
                        $error("crc_error: expected %0b, got %0b", rd.crc_err, crc_error);
                        n_errors++;
                    end
                end
            end
            stall_pct = (idle_phase == 0) ? 80 : (idle_phase == 1) ? 32 : 0;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!hold_done && n_readings >= 20)
            begin
                // long back-pressure so the input side fills and stalls
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    initial
    begin
        bit clean;
        // directed: saturation high, dropped partial frame, saturation low,
        // frame with no start after a CRC byte: raw word with bad CRC
        add_frame(16'h7FFF, 8'h00, owtsd_pkg::EXT_FAMILY, 1'b1, 1'b0);
        add_noise(3);
        add_frame(16'h8000, 8'hFF, owtsd_pkg::EXT_FAMILY, 1'b1, 1'b0);
        add_frame(16'hFFFF, 8'h10, 8'hFF, 1'b0, 1'b1);
        clean = 1'b1;
        while (pending_bytes.size() < N_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                add_noise($urandom_range(1, 8));
                clean = 1'b0;
            end
            else
            begin
                add_frame(pick_temp(),
                          ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 16)) : 8'($urandom),
                          ($urandom_range(0, 1) == 0) ? owtsd_pkg::EXT_FAMILY : 8'($urandom),
                          !clean || ($urandom_range(0, 3) != 0),
                          $urandom_range(0, 9) == 0);
                clean = 1'b1;
            end
        end
        n_total = pending_bytes.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || in_valid)
        begin
            @(posedge clk);
        end
        while (expected_readings.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        $display("tb: %0d bytes sent, %0d frames ended, %0d items checked", n_taken, n_frames,
                 n_readings);
        $display("tb: %0d extended-format (%0d clamped), %0d CRC mismatches", n_ext, n_sat,
                 n_bad_crc);
        if (n_errors == 0)
        begin
            $display("tb: clean");
        end
        else
        begin
            $display("tb: errors");
        end
        $finish;
    end

    initial
    begin
        #2ms;
        $display("tb: errors");
        $finish;
    end

endmodule

### onewire_temp_scratchpad_decode.f
hdl/owtsd_pkg.sv
hdl/owtsd_temp.sv
hdl/onewire_temp_scratchpad_decode.sv
tb/sv/tb.sv
